// ----- hdl/skin_weight_top4_select_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef SKIN_WEIGHT_TOP4_SELECT_MACROS_SVH
`define SKIN_WEIGHT_TOP4_SELECT_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define SWTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swts assertion failed");

// Next-cycle implication under the active-low reset.
`define SWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swts assertion failed");

`endif

// ----- hdl/swts_pkg.sv -----
package swts_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int SLOTS_DEF        = 4;

    localparam int VERTEX_W  = 12;
    localparam int BONE_W    = 8;
    localparam int WEIGHT_W  = 16;
    localparam int PAIR_W    = BONE_W + WEIGHT_W;
    localparam int OUT_SLOTS = 4;

    localparam logic [BONE_W-1:0] EMPTY_BONE = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ----- hdl/swts_slot_ram.sv -----
module swts_slot_ram
    import swts_pkg::*;
#(
    parameter int DEPTH = VERTEX_DEPTH_DEF,
    parameter int AW    = 12,
    parameter int DW    = SLOTS_DEF * PAIR_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/skin_weight_top4_select.sv -----
// Per-vertex top bone influence selector. Each item (vertex, bone, weight) is merged into
// that vertex's list of up to SLOTS influences kept from largest weight to smallest, and
// one result item with the vertex's four reported slots follows every input item. An item
// passes through accept, the registered read of the slot memory, a scan by the single
// weight comparator that visits one slot per step and stops at the insert point (it is
// skipped for an ignored item), and a write step that stores the word back when an insert
// point was found and loads the output register. The write step waits while the previous
// result item is still waiting for m_tready. After reset a clearing pass writes every one
// of the VERTEX_DEPTH memory words, one per cycle, before the first item is taken.
`include "skin_weight_top4_select_macros.svh"

module skin_weight_top4_select
    import swts_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int SLOTS        = SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_sel[11:0], bone_sel[19:12], influence[35:20], zero pad
    input  logic [39:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_out[11:0], bone_a..bone_d[43:12], weight_a..weight_d[107:44], zero pad
    output logic [111:0] m_tdata
);

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = SLOTS * PAIR_W;
    localparam int XW = 17;
    localparam logic [DW-1:0] EMPTY_WORD = {SLOTS{{WEIGHT_W{1'b0}}, EMPTY_BONE}};

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [VERTEX_W-1:0]  vtx_reg, vtx_next;
    logic [BONE_W-1:0]    bone_reg, bone_next;
    logic [WEIGHT_W-1:0]  wt_reg, wt_next;
    logic [SW-1:0]        idx_reg, idx_next;
    logic [SW-1:0]        pos_reg, pos_next;
    logic                 ins_reg, ins_next;
    logic                 m_valid_reg, m_valid_next;
    logic [111:0]         m_data_reg, m_data_next;

    logic [XW-1:0]        vtx_ext;
    logic                 in_range;
    logic [AW-1:0]        addr;
    logic [DW-1:0]        rd_data;
    logic [DW-1:0]        new_word;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;
    logic                 out_free;
    logic                 hit;

    logic [BONE_W-1:0]    old_bone [SLOTS];
    logic [WEIGHT_W-1:0]  old_wt   [SLOTS];
    logic [BONE_W-1:0]    out_bone [OUT_SLOTS];
    logic [WEIGHT_W-1:0]  out_wt   [OUT_SLOTS];

    assign vtx_ext  = {{(XW - VERTEX_W){1'b0}}, vtx_reg};
    assign in_range = vtx_ext < XW'(VERTEX_DEPTH);
    assign addr     = vtx_ext[AW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    for (genvar j = 0; j < SLOTS; j++) begin : g_slot
        assign old_bone[j] = rd_data[j*PAIR_W +: BONE_W];
        assign old_wt[j]   = rd_data[j*PAIR_W + BONE_W +: WEIGHT_W];
        if (j == 0) begin : g_first
            always_comb begin
                if (ins_reg && pos_reg == SW'(j)) begin
                    new_word[j*PAIR_W +: PAIR_W] = {wt_reg, bone_reg};
                end else begin
                    new_word[j*PAIR_W +: PAIR_W] = {old_wt[j], old_bone[j]};
                end
            end
        end else begin : g_rest
            always_comb begin
                if (ins_reg && pos_reg == SW'(j)) begin
                    new_word[j*PAIR_W +: PAIR_W] = {wt_reg, bone_reg};
                end else if (ins_reg && pos_reg < SW'(j)) begin
                    new_word[j*PAIR_W +: PAIR_W] = {old_wt[j-1], old_bone[j-1]};
                end else begin
                    new_word[j*PAIR_W +: PAIR_W] = {old_wt[j], old_bone[j]};
                end
            end
        end
    end

    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out
        if (j < SLOTS) begin : g_held
            always_comb begin
                if (in_range) begin
                    out_bone[j] = new_word[j*PAIR_W +: BONE_W];
                    out_wt[j]   = new_word[j*PAIR_W + BONE_W +: WEIGHT_W];
                end else begin
                    out_bone[j] = EMPTY_BONE;
                    out_wt[j]   = '0;
                end
            end
        end else begin : g_none
            assign out_bone[j] = EMPTY_BONE;
            assign out_wt[j]   = '0;
        end
    end

    assign hit = (old_bone[idx_reg] == EMPTY_BONE) || (old_wt[idx_reg] < wt_reg);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        vtx_next     = vtx_reg;
        bone_next    = bone_reg;
        wt_next      = wt_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        ins_next     = ins_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = addr;
        wr_data      = new_word;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = EMPTY_WORD;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(VERTEX_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    vtx_next   = s_tdata[11:0];
                    bone_next  = s_tdata[19:12];
                    wt_next    = s_tdata[35:20];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                idx_next = '0;
                pos_next = '0;
                ins_next = 1'b0;
                if (in_range && bone_reg != EMPTY_BONE) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    pos_next   = idx_reg;
                    ins_next   = 1'b1;
                    state_next = ST_WRITE;
                end else if (idx_reg == SW'(SLOTS - 1)) begin
                    state_next = ST_WRITE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    wr_en        = ins_reg;
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0,
                                    out_wt[3], out_wt[2], out_wt[1], out_wt[0],
                                    out_bone[3], out_bone[2], out_bone[1], out_bone[0],
                                    vtx_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            ins_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ins_reg     <= ins_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vtx_reg    <= vtx_next;
        bone_reg   <= bone_next;
        wt_reg     <= wt_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    swts_slot_ram #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SWTS_ASSERT_NEXT(a_accept_reads, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_READ)
    `SWTS_ASSERT_NEXT(a_write_delivers, aclk, aresetn, state_reg == ST_WRITE && out_free, m_tvalid && s_tready)
    `SWTS_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && m_tdata[19:12] == EMPTY_BONE, m_tdata[59:44] == '0)
    `SWTS_ASSERT_NOW(a_scan_bound, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= SW'(SLOTS - 1))

endmodule

// ----- verif/skin_weight_top4_select_test.sv -----
`timescale 1ns / 1ps

module skin_weight_top4_select_test;
    import swts_pkg::*;

    localparam int RES_W = OUT_SLOTS * (BONE_W + WEIGHT_W) + VERTEX_W;

    typedef struct packed {
        logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] wt;
        logic [OUT_SLOTS-1:0][BONE_W-1:0]   bone;
        logic [VERTEX_W-1:0]                vertex;
    } slots_t;

    typedef struct {
        logic [VERTEX_W-1:0] v;
        logic [BONE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        bit                  known;
        slots_t              res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;

    skin_weight_top4_select dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // per-vertex influence lists, largest weight first
    logic [BONE_W-1:0]   inf_bone [VERTEX_DEPTH_DEF][SLOTS_DEF];
    logic [WEIGHT_W-1:0] inf_wt   [VERTEX_DEPTH_DEF][SLOTS_DEF];

    slots_t   slots_expected [$];
    dir_row_t dir_rows [$];
    int       mismatch_cnt = 0;
    bit       idle_off = 0;

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic slots_t merge_influence(input logic [VERTEX_W-1:0] v,
                                               input logic [BONE_W-1:0] b,
                                               input logic [WEIGHT_W-1:0] w);
        slots_t r;
        int     pos;
        int     i;
        pos = -1;
        if (int'(v) < VERTEX_DEPTH_DEF && b != EMPTY_BONE) begin
            for (i = 0; i < SLOTS_DEF; i++) begin
                if (pos < 0 && (inf_bone[v][i] == EMPTY_BONE || inf_wt[v][i] < w))
                    pos = i;
            end
            if (pos >= 0) begin
                for (i = SLOTS_DEF - 1; i > pos; i--) begin
                    inf_bone[v][i] = inf_bone[v][i-1];
                    inf_wt[v][i]   = inf_wt[v][i-1];
                end
                inf_bone[v][pos] = b;
                inf_wt[v][pos]   = w;
            end
        end
        r.vertex = v;
        for (i = 0; i < OUT_SLOTS; i++) begin
            if (i < SLOTS_DEF && int'(v) < VERTEX_DEPTH_DEF) begin
                r.bone[i] = inf_bone[v][i];
                r.wt[i]   = inf_wt[v][i];
            end else begin
                r.bone[i] = EMPTY_BONE;
                r.wt[i]   = '0;
            end
        end
        return r;
    endfunction

    function automatic slots_t mk_slots(input logic [VERTEX_W-1:0] v,
                                        input logic [BONE_W-1:0] b0, b1, b2, b3,
                                        input logic [WEIGHT_W-1:0] w0, w1, w2, w3);
        slots_t r;
        r.vertex = v;
        r.bone   = {b3, b2, b1, b0};
        r.wt     = {w3, w2, w1, w0};
        return r;
    endfunction

    function automatic void add_row(input logic [VERTEX_W-1:0] v, input logic [BONE_W-1:0] b,
                                    input logic [WEIGHT_W-1:0] w, input bit known,
                                    input slots_t res);
        dir_row_t row;
        row.v     = v;
        row.b     = b;
        row.w     = w;
        row.known = known;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int e, input int a);
        if (e != a) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, e, a);
        end
    endfunction

    task automatic send_item(input logic [VERTEX_W-1:0] v, input logic [BONE_W-1:0] b,
                             input logic [WEIGHT_W-1:0] w, input bit known,
                             input slots_t typed);
        int     gap;
        slots_t pred;
        gap = idle_off ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {4'b0, w, b, v};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pred = merge_influence(v, b, w);
        slots_expected.push_back(known ? typed : pred);
        @(negedge aclk);
    endtask

    // result side
    initial begin
        int     stall;
        slots_t got;
        slots_t want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = slots_t'(m_tdata[RES_W-1:0]);
            if (slots_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result item: vertex %0d", got.vertex);
            end else begin
                want = slots_expected.pop_front();
                check_field("vertex_out", int'(want.vertex), int'(got.vertex));
                check_field("bone_a", int'(want.bone[0]), int'(got.bone[0]));
                check_field("bone_b", int'(want.bone[1]), int'(got.bone[1]));
                check_field("bone_c", int'(want.bone[2]), int'(got.bone[2]));
                check_field("bone_d", int'(want.bone[3]), int'(got.bone[3]));
                check_field("weight_a", int'(want.wt[0]), int'(got.wt[0]));
                check_field("weight_b", int'(want.wt[1]), int'(got.wt[1]));
                check_field("weight_c", int'(want.wt[2]), int'(got.wt[2]));
                check_field("weight_d", int'(want.wt[3]), int'(got.wt[3]));
            end
            @(negedge aclk);
        end
    end

    initial begin
        #2000000;
        $display("skin_weight_top4_select_test: FAIL");
        $finish;
    end

    initial begin
        logic [VERTEX_W-1:0] pool [24];
        logic [WEIGHT_W-1:0] tie_w [5];
        logic [VERTEX_W-1:0] v;
        logic [BONE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        int                  k;
        slots_t              none;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        none     = '0;
        for (int i = 0; i < VERTEX_DEPTH_DEF; i++) begin
            for (int j = 0; j < SLOTS_DEF; j++) begin
                inf_bone[i][j] = EMPTY_BONE;
                inf_wt[i][j]   = '0;
            end
        end

        add_row(12'd0, 8'd0, 16'd0, 1'b1,
                mk_slots(12'd0, 8'd0, EMPTY_BONE, EMPTY_BONE, EMPTY_BONE,
                         16'd0, 16'd0, 16'd0, 16'd0));
        // empty-mark bone is ignored
        add_row(12'd4095, EMPTY_BONE, 16'hFFFF, 1'b1,
                mk_slots(12'd4095, EMPTY_BONE, EMPTY_BONE, EMPTY_BONE, EMPTY_BONE,
                         16'd0, 16'd0, 16'd0, 16'd0));
        add_row(12'd4095, 8'd254, 16'hFFFF, 1'b1,
                mk_slots(12'd4095, 8'd254, EMPTY_BONE, EMPTY_BONE, EMPTY_BONE,
                         16'hFFFF, 16'd0, 16'd0, 16'd0));
        // tie keeps the earlier record first
        add_row(12'd4095, 8'd1, 16'hFFFF, 1'b1,
                mk_slots(12'd4095, 8'd254, 8'd1, EMPTY_BONE, EMPTY_BONE,
                         16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
        add_row(12'd4095, 8'd2, 16'd100, 1'b0, none);
        add_row(12'd4095, 8'd3, 16'd200, 1'b0, none);
        add_row(12'd4095, 8'd4, 16'd50, 1'b0, none);     // full, smaller: dropped
        add_row(12'd4095, 8'd5, 16'd100, 1'b0, none);    // full, equal to last: dropped
        add_row(12'd4095, 8'd6, 16'hFFFF, 1'b0, none);
        add_row(12'd4095, EMPTY_BONE, 16'd0, 1'b0, none);
        add_row(12'd0, 8'd7, 16'd1, 1'b0, none);
        add_row(12'hAAA, 8'hAA, 16'hAAAA, 1'b0, none);
        add_row(12'h555, 8'h55, 16'h5555, 1'b0, none);
        for (int i = 1; i <= 5; i++)
            add_row(12'h123, 8'(9 + i), 16'(i), 1'b0, none);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].v, dir_rows[i].b, dir_rows[i].w, dir_rows[i].known,
                      dir_rows[i].res);

        s_tvalid <= 1'b0;
        wait (slots_expected.size() == 0);
        @(negedge aclk);

        for (int i = 0; i < 24; i++)
            pool[i] = 12'($urandom_range(0, 4095));
        tie_w = '{16'd0, 16'd1, 16'd1000, 16'h8000, 16'hFFFF};

        for (int n = 0; n < 850; n++) begin
            idle_off = ((n / 100) % 3 == 2);
            if (n == 425) begin
                s_tvalid <= 1'b0;
                wait (slots_expected.size() == 0);
                @(negedge aclk);
            end
            k = $urandom_range(0, 99);
            v = (k < 80) ? pool[$urandom_range(0, 23)] : 12'($urandom_range(0, 4095));
            b = (k < 92) ? 8'($urandom_range(0, 254)) : EMPTY_BONE;
            w = ($urandom_range(0, 3) == 0) ? tie_w[$urandom_range(0, 4)]
                                            : 16'($urandom_range(0, 65535));
            send_item(v, b, w, 1'b0, none);
        end

        s_tvalid <= 1'b0;
        wait (slots_expected.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("skin_weight_top4_select_test: PASS");
        end else begin
            $display("skin_weight_top4_select_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- skin_weight_top4_select.f -----
+incdir+hdl
hdl/swts_pkg.sv
hdl/swts_slot_ram.sv
hdl/skin_weight_top4_select.sv
verif/skin_weight_top4_select_test.sv
